// File: sv/irad_pkg.sv
package irad_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int RADICAL_WIDTH   = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_SDIV,
        ST_SCHECK,
        ST_MULD,
        ST_XSTART,
        ST_XDIV,
        ST_XCHECK,
        ST_MULN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic mul_d;
        logic take_q;
        logic next_d;
        logic mul_n;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic d_gt_q;
        logic rem_zero;
        logic n_gt_one;
        logic zero;
    } stat_t;

endpackage

// File: sv/irad_div.sv
module irad_div import irad_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quot,
    output logic [VALUE_WIDTH-1:0] rem
);

    localparam int CW = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] quot_reg, quot_next;
    logic [VALUE_WIDTH:0]   rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] div_reg, div_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   div_ext;

    assign trial   = {rem_reg[VALUE_WIDTH-1:0], quot_reg[VALUE_WIDTH-1]};
    assign div_ext = {1'b0, div_reg};

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= div_ext)
            begin
                rem_next  = trial - div_ext;
                quot_next = {quot_reg[VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(VALUE_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
            div_reg  <= div_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg[VALUE_WIDTH-1:0];

`ifndef SYNTHESIS
    // A new division is never started while one is still running.
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("division started while busy");

    // A finished division leaves a remainder below the divisor.
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < div_ext))
        else $error("remainder not below divisor");
`endif

endmodule

// File: sv/irad_dp.sv
module irad_dp import irad_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output stat_t                    stat,
    input  logic [VALUE_WIDTH-1:0]   value,
    output logic [RADICAL_WIDTH-1:0] radical,
    output logic                     zero_error
);

    logic [VALUE_WIDTH-1:0]     n_reg, n_next;
    logic [VALUE_WIDTH-1:0]     d_reg, d_next;
    logic [RADICAL_WIDTH-1:0]   r_reg, r_next;
    logic                       zero_reg, zero_next;
    logic                       div_done;
    logic [VALUE_WIDTH-1:0]     quot;
    logic [VALUE_WIDTH-1:0]     rem;
    logic [RADICAL_WIDTH-1:0]   d_ext;
    logic [RADICAL_WIDTH-1:0]   n_ext;
    logic [RADICAL_WIDTH-1:0]   mul_b;
    logic [2*RADICAL_WIDTH-1:0] prod;

    irad_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .dividend(n_reg),
        .divisor (d_reg),
        .done    (div_done),
        .quot    (quot),
        .rem     (rem)
    );

    // Only the low bits of the product reach the result, so the low bits of
    // each factor suffice.
    assign d_ext = RADICAL_WIDTH'(d_reg);
    assign n_ext = RADICAL_WIDTH'(n_reg);
    assign mul_b = cmd.mul_n ? n_ext : d_ext;
    assign prod  = r_reg * mul_b;

    always_comb
    begin
        n_next    = n_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        zero_next = zero_reg;
        if (cmd.load)
        begin
            n_next    = value;
            d_next    = VALUE_WIDTH'(2);
            zero_next = (value == '0);
            r_next    = (value == '0) ? '0 : RADICAL_WIDTH'(1);
        end
        if (cmd.mul_d)
        begin
            r_next = prod[RADICAL_WIDTH-1:0];
            n_next = quot;
        end
        if (cmd.take_q)
        begin
            n_next = quot;
        end
        if (cmd.next_d)
        begin
            d_next = (d_reg == VALUE_WIDTH'(2)) ? VALUE_WIDTH'(3)
                                                : d_reg + VALUE_WIDTH'(2);
        end
        if (cmd.mul_n)
        begin
            r_next = prod[RADICAL_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            d_reg    <= VALUE_WIDTH'(2);
            r_reg    <= '0;
            zero_reg <= 1'b0;
        end
        else
        begin
            n_reg    <= n_next;
            d_reg    <= d_next;
            r_reg    <= r_next;
            zero_reg <= zero_next;
        end
    end

    assign stat.div_done = div_done;
    assign stat.d_gt_q   = (d_reg > quot);
    assign stat.rem_zero = (rem == '0);
    assign stat.n_gt_one = (n_reg > VALUE_WIDTH'(1));
    assign stat.zero     = zero_reg;

    assign radical    = r_reg;
    assign zero_error = zero_reg;

`ifndef SYNTHESIS
    // The trial divisor is two or an odd number.
    a_d_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (d_reg == VALUE_WIDTH'(2)) || d_reg[0])
        else $error("trial divisor is even and not two");

    // A zero request always carries a zero radical.
    a_zero_rad: assert property (@(posedge clk) disable iff (!rst_n)
        zero_reg |-> (r_reg == '0))
        else $error("zero request with nonzero radical");
`endif

endmodule

// File: sv/irad_ctrl.sv
module irad_ctrl import irad_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    output cmd_t  cmd,
    input  stat_t stat
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = stat.zero ? ST_OUT : ST_SDIV;
            end
            ST_SDIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_SCHECK;
                end
            end
            ST_SCHECK:
            begin
                if (stat.d_gt_q)
                begin
                    state_next = stat.n_gt_one ? ST_MULN : ST_OUT;
                end
                else if (stat.rem_zero)
                begin
                    state_next = ST_MULD;
                end
                else
                begin
                    state_next = ST_START;
                end
            end
            ST_MULD:
            begin
                state_next = ST_XSTART;
            end
            ST_XSTART:
            begin
                state_next = ST_XDIV;
            end
            ST_XDIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_XCHECK;
                end
            end
            ST_XCHECK:
            begin
                state_next = stat.rem_zero ? ST_XSTART : ST_START;
            end
            ST_MULN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_START:
            begin
                cmd.div_start = !stat.zero;
            end
            ST_SCHECK:
            begin
                cmd.next_d = !stat.d_gt_q && !stat.rem_zero;
            end
            ST_MULD:
            begin
                cmd.mul_d = 1'b1;
            end
            ST_XSTART:
            begin
                cmd.div_start = 1'b1;
            end
            ST_XCHECK:
            begin
                cmd.take_q = stat.rem_zero;
                cmd.next_d = !stat.rem_zero;
            end
            ST_MULN:
            begin
                cmd.mul_n = 1'b1;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/integer_radical.sv
// Each trial divisor takes one bit-serial division, and each extra division strips
// a repeated factor; setup and output states come before and after them.
// Trial divisors run up to the square root of the value, and only one request is in
// flight at a time. The asynchronous active-low reset returns the block to idle with
// no result pending.
module integer_radical import irad_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [VALUE_WIDTH-1:0]   value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [RADICAL_WIDTH-1:0] radical,
    output logic                     zero_error
);

    cmd_t  cmd;
    stat_t stat;

    irad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    irad_dp #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .value     (value),
        .radical   (radical),
        .zero_error(zero_error)
    );

endmodule

// File: tb/testbench.sv
module testbench;

    localparam int VW        = irad_pkg::VALUE_WIDTH_DEF;
    localparam int RW        = irad_pkg::RADICAL_WIDTH;
    localparam int RANDOM_N  = 80;
    localparam int CALM_N    = 20;
    localparam int LIMIT     = 10_000_000;

    class radical_scoreboard;
        typedef struct {
            logic [VW-1:0] value;
            logic [RW-1:0] radical;
            logic          zero_error;
        } radical_result_t;

        radical_result_t pending_radicals[$];
        int errors;
        int requests;
        int results;
        int zero_inputs;

        // Trial division: strip 2, then odd candidates while d*d <= n.
        function radical_result_t predict_radical(logic [VW-1:0] v);
            radical_result_t res;
            bit [63:0] n;
            bit [63:0] r;
            bit [63:0] d;
            n = v;
            res.value = v;
            if (n == 0)
            begin
                res.radical    = '0;
                res.zero_error = 1'b1;
                return res;
            end
            r = 1;
            if (n[0] == 1'b0)
            begin
                r = 2;
                while (n % 2 == 0)
                    n = n / 2;
            end
            d = 3;
            while (d <= n / d)
            begin
                if (n % d == 0)
                begin
                    r = r * d;
                    while (n % d == 0)
                        n = n / d;
                end
                d = d + 2;
            end
            if (n > 1)
                r = r * n;
            res.radical    = r[RW-1:0];
            res.zero_error = 1'b0;
            return res;
        endfunction

        function void note(logic [VW-1:0] v);
            pending_radicals.insert(pending_radicals.size(), predict_radical(v));
            requests++;
            if (v == 0)
                zero_inputs++;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check(logic [RW-1:0] rad, logic zerr);
            radical_result_t exp_res;
            results++;
            if (pending_radicals.size() == 0)
            begin
                report($sformatf("result radical=%0d zero_error=%0b with no request waiting",
                                 rad, zerr));
                return;
            end
            exp_res = pending_radicals.pop_front();
            if (rad !== exp_res.radical)
                report($sformatf("value=%0d radical=%0d, predicted %0d",
                                 exp_res.value, rad, exp_res.radical));
            if (zerr !== exp_res.zero_error)
                report($sformatf("value=%0d zero_error=%0b, predicted %0b",
                                 exp_res.value, zerr, exp_res.zero_error));
        endtask

        function int pending();
            return pending_radicals.size();
        endfunction
    endclass

    logic          clk        = 1'b0;
    logic          rst_n      = 1'b0;
    logic          in_valid   = 1'b0;
    logic          in_ready;
    logic [VW-1:0] value      = '0;
    logic          out_valid;
    logic          out_ready  = 1'b0;
    logic [RW-1:0] radical;
    logic          zero_error;

    radical_scoreboard sb = new();
    bit idle_en = 1'b1;
    int cycle_count = 0;

    integer_radical dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .radical    (radical),
        .zero_error (zero_error)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note(value);
        if (rst_n && out_valid && out_ready)
            sb.check(radical, zero_error);
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        forever
        begin
            if (idle_en && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    task send_value(logic [VW-1:0] v);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Values are built so that the odd part left after small factors stays
    // below about 2^20; that keeps every trial-division pass short.
    function automatic logic [VW-1:0] random_value();
        bit [63:0] v;
        int unsigned f;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 5)
        begin
            v = 1;
            repeat ($urandom_range(1, 10))
            begin
                f = $urandom_range(2, 97);
                if (v * f <= 64'hFFFF_FFFF)
                    v = v * f;
            end
        end
        else if (kind < 7)
            v = $urandom_range(0, 65535);
        else if (kind < 9)
            v = 64'($urandom_range(1, (1 << 20) - 1)) << $urandom_range(0, 12);
        else
            v = 64'($urandom_range(0, 65535)) << 16;
        return v[VW-1:0];
    endfunction

    logic [VW-1:0] directed_values[] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'hFFFF_FFFF, 32'h8000_0000,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000, 32'd65521,
        32'd65536, 32'd9699690, 32'd223092870, 32'd3486784401, 32'd1000003,
        32'd44100, 32'd88529281, 32'd901800900, 32'd49, 32'd0
    };

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_values[i])
            send_value(directed_values[i]);

        // Hold off new requests until the block has answered everything.
        in_valid <= 1'b0;
        @(posedge clk);
        wait_drained();

        for (int i = 0; i < RANDOM_N; i++)
        begin
            idle_en = (i < RANDOM_N - CALM_N);
            send_value(random_value());
        end
        in_valid <= 1'b0;
        @(posedge clk);

        wait_drained();
        repeat (60) @(posedge clk);

        $display("Covered %0d requests (%0d directed, %0d with zero input), %0d results.",
                 sb.requests, directed_values.size(), sb.zero_inputs, sb.results);
        $display("%s%s", "Inputs spanned zero, one, all-ones, powers of two, primorials and ",
                 "random smooth numbers, with random idling on both sides.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// File: sim.f
sv/irad_pkg.sv
sv/irad_div.sv
sv/irad_dp.sv
sv/irad_ctrl.sv
sv/integer_radical.sv
tb/testbench.sv
